/* src/rhc_pkg.sv */
// Types, constants and the divider step shared by the RGB/HSV converter.
// No dependencies; compiled first.
package rhc_pkg;

	typedef enum logic {
		MODE_TO_HSV = 1'b0,
		MODE_TO_RGB = 1'b1
	} mode_t;

	localparam logic [7:0] HUE_SPAN  = 8'd43;
	localparam logic [7:0] BASE_RED  = 8'd0;
	localparam logic [7:0] BASE_GRN  = 8'd85;
	localparam logic [7:0] BASE_BLU  = 8'd171;
	localparam logic [7:0] FULL      = 8'd255;
	localparam logic [7:0] REM_SCALE = 8'd6;
	localparam int         NUM_REGIONS = 6;

	// Restoring divider geometry: 8 quotient bits, two per stage
	localparam int QW         = 8;
	localparam int DVD_W      = 2 * QW;
	localparam int DIV_STEP   = 2;
	localparam int DIV_STAGES = QW / DIV_STEP;
	localparam int PIPE_DEPTH = DIV_STAGES + 2;
	localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

	typedef struct packed {
		mode_t      mode;
		logic [7:0] chan_a;
		logic [7:0] chan_b;
		logic [7:0] chan_c;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_a;
		logic [7:0] out_b;
		logic [7:0] out_c;
	} result_t;

	// Everything an item carries down the pipeline, for both modes
	typedef struct packed {
		mode_t            mode;
		logic             is_black;
		logic             is_grey;
		logic             neg;
		logic [7:0]       base;
		logic [7:0]       hi;       // max channel, or value in HSV to RGB
		logic [7:0]       diff;
		logic [DVD_W-1:0] sat_dvd;
		logic [QW-1:0]    sat_rem;
		logic [QW-1:0]    sat_q;
		logic [DVD_W-1:0] hue_dvd;
		logic [QW-1:0]    hue_rem;
		logic [QW-1:0]    hue_q;
		logic             s_zero;
		logic [2:0]       region;
		logic [7:0]       p;
		logic [7:0]       sr_hi;
		logic [7:0]       st_hi;
	} pipe_t;

	typedef struct packed {
		logic [QW-1:0] rem;
		logic          q;
	} div_res_t;

	// One restoring step: shift in a dividend bit, subtract if it fits
	function automatic div_res_t div_step(logic [QW-1:0] rem, logic dbit,
			logic [QW-1:0] divisor);
		logic [QW:0] trial;
		div_res_t    r;
		trial = {rem, dbit};
		if (trial >= {1'b0, divisor}) begin
			r.rem = QW'(trial - {1'b0, divisor});
			r.q   = 1'b1;
		end else begin
			r.rem = trial[QW-1:0];
			r.q   = 1'b0;
		end
		return r;
	endfunction

endpackage

/* src/rhc_if.sv */
// Valid/ready channel carrying one item of payload type T.
// No dependencies.
interface rhc_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* src/rgb_hsv_converter.sv */
// RGB <-> HSV pixel converter, 8-bit channels. Pipeline from accept to result valid:
// front stage, four divider stages of two quotient bits each, output.
// Throughput: one item per cycle; each stage holds one item and stalls only
// when the stage after it is full and stalled, so bubbles close up.
// Reset clears all valid bits; payload registers are not reset.
// Depends on rhc_pkg, rhc_if, rhc_front, rhc_div_stage, rhc_back.
module rgb_hsv_converter import rhc_pkg::*; (
	input logic clk,
	input logic arst_n,
	rhc_if.sink   pixel,
	rhc_if.source result
);

	pipe_t             stg_data [DIV_STAGES+1];
	logic [DIV_STAGES:0] stg_valid;
	logic [DIV_STAGES:0] stg_ready;
	logic [CNT_W-1:0]  inflight_q;

	rhc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.in_data   (pixel.data),
		.out_valid (stg_valid[0]),
		.out_ready (stg_ready[0]),
		.out_data  (stg_data[0])
	);

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		rhc_div_stage #(.STAGE(i)) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[i]),
			.in_ready  (stg_ready[i]),
			.in_data   (stg_data[i]),
			.out_valid (stg_valid[i+1]),
			.out_ready (stg_ready[i+1]),
			.out_data  (stg_data[i+1])
		);
	end

	rhc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stg_valid[DIV_STAGES]),
		.in_ready  (stg_ready[DIV_STAGES]),
		.in_data   (stg_data[DIV_STAGES]),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (result.data)
	);

	// count items between input and output handshakes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(pixel.valid && pixel.ready)
				- CNT_W'(result.valid && result.ready);
		end
	end

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == CNT_W'($countones({result.valid, stg_valid})))
		else $error("item count does not match stage valid bits");

	a_front_free: assert property (@(posedge clk) disable iff (!arst_n)
		!stg_valid[0] |-> pixel.ready)
		else $error("input stalled with an empty front stage");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == CNT_W'(PIPE_DEPTH)) && !result.ready |-> !pixel.ready)
		else $error("input taken while pipeline full and output stalled");

endmodule

/* src/rhc_front.sv */
// First stage: max/min, sector and dividends for RGB to HSV; region and
// first products for HSV to RGB. Depends on rhc_pkg.
module rhc_front import rhc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  pixel_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output pipe_t  out_data
);

	logic        valid_s1;
	pipe_t       data_s1;
	pipe_t       nxt;
	logic [7:0]  ca, cb, cc;
	logic [7:0]  hi_m, lo_m, diff;
	logic        is_r, is_g;
	logic [8:0]  num;
	logic [7:0]  mag;
	logic [2:0]  region;
	logic [7:0]  seg_start, rem, rem6;
	logic [15:0] sr, st, pv, sat_dvd, hue_dvd;

	assign ca = in_data.chan_a;
	assign cb = in_data.chan_b;
	assign cc = in_data.chan_c;

	always_comb begin
		hi_m = (ca > cb) ? ca : cb;
		hi_m = (hi_m > cc) ? hi_m : cc;
		lo_m = (ca < cb) ? ca : cb;
		lo_m = (lo_m < cc) ? lo_m : cc;
		diff = hi_m - lo_m;
		// red wins ties over green, green over blue
		is_r = (hi_m == ca);
		is_g = (hi_m == cb);
		if (is_r) begin
			num = {1'b0, cb} - {1'b0, cc};
		end else if (is_g) begin
			num = {1'b0, cc} - {1'b0, ca};
		end else begin
			num = {1'b0, ca} - {1'b0, cb};
		end
		mag = num[8] ? 8'(-num) : num[7:0];
		sat_dvd = {diff, 8'd0} - 16'(diff);
		hue_dvd = 16'(mag) * 16'(HUE_SPAN);
	end

	always_comb begin
		region    = '0;
		seg_start = '0;
		for (int k = 1; k < NUM_REGIONS; k++) begin
			if (ca >= 8'(k * HUE_SPAN)) begin
				region    = 3'(k);
				seg_start = 8'(k * HUE_SPAN);
			end
		end
		rem  = ca - seg_start;
		rem6 = 8'(rem * REM_SCALE);
		sr   = 16'(cb) * 16'(rem6);
		st   = 16'(cb) * 16'(FULL - rem6);
		pv   = 16'(cc) * 16'(FULL - cb);
	end

	always_comb begin
		nxt          = '0;
		nxt.mode     = in_data.mode;
		nxt.is_black = (hi_m == 8'd0);
		nxt.is_grey  = (diff == 8'd0);
		nxt.neg      = num[8];
		nxt.base     = is_r ? BASE_RED : (is_g ? BASE_GRN : BASE_BLU);
		nxt.hi       = (in_data.mode == MODE_TO_RGB) ? cc : hi_m;
		nxt.diff     = diff;
		nxt.sat_dvd  = sat_dvd;
		nxt.sat_rem  = sat_dvd[DVD_W-1:QW];
		nxt.hue_dvd  = hue_dvd;
		nxt.hue_rem  = hue_dvd[DVD_W-1:QW];
		nxt.s_zero   = (cb == 8'd0);
		nxt.region   = region;
		nxt.p        = pv[15:8];
		nxt.sr_hi    = sr[15:8];
		nxt.st_hi    = st[15:8];
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

/* src/rhc_div_stage.sv */
// One divider stage: two restoring steps each for saturation and hue.
// Depends on rhc_pkg.
module rhc_div_stage import rhc_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  pipe_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output pipe_t out_data
);

	logic     valid_q;
	pipe_t    data_q;
	pipe_t    nxt;
	div_res_t sres, hres;

	always_comb begin
		nxt = in_data;
		for (int j = 0; j < DIV_STEP; j++) begin
			sres = div_step(nxt.sat_rem, nxt.sat_dvd[QW-1-STAGE*DIV_STEP-j], nxt.hi);
			hres = div_step(nxt.hue_rem, nxt.hue_dvd[QW-1-STAGE*DIV_STEP-j], nxt.diff);
			nxt.sat_rem = sres.rem;
			nxt.sat_q[QW-1-STAGE*DIV_STEP-j] = sres.q;
			nxt.hue_rem = hres.rem;
			nxt.hue_q[QW-1-STAGE*DIV_STEP-j] = hres.q;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

/* src/rhc_back.sv */
// Last stage: hue sum and masking for HSV, q and t products and region
// select for RGB, into the output register. Depends on rhc_pkg.
module rhc_back import rhc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  pipe_t   in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic        valid_q;
	result_t     data_q;
	result_t     nxt;
	logic [7:0]  off, hue, v, qv, tv, p;
	logic [15:0] qp, tp;

	assign v  = in_data.hi;
	assign p  = in_data.p;
	assign qp = 16'(v) * 16'(FULL - in_data.sr_hi);
	assign tp = 16'(v) * 16'(FULL - in_data.st_hi);
	assign qv = qp[15:8];
	assign tv = tp[15:8];

	// truncated magnitude quotient, sign restored; sum wraps
	assign off = in_data.neg ? 8'(-in_data.hue_q) : in_data.hue_q;
	assign hue = in_data.base + off;

	always_comb begin
		if (in_data.mode == MODE_TO_HSV) begin
			nxt.out_a = in_data.is_grey ? 8'd0 : hue;
			nxt.out_b = in_data.is_black ? 8'd0 : in_data.sat_q;
			nxt.out_c = in_data.hi;
		end else if (in_data.s_zero) begin
			nxt = '{out_a: v, out_b: v, out_c: v};
		end else begin
			unique case (in_data.region)
				3'd0:    nxt = '{out_a: v,  out_b: tv, out_c: p};
				3'd1:    nxt = '{out_a: qv, out_b: v,  out_c: p};
				3'd2:    nxt = '{out_a: p,  out_b: v,  out_c: tv};
				3'd3:    nxt = '{out_a: p,  out_b: qv, out_c: v};
				3'd4:    nxt = '{out_a: tv, out_b: p,  out_c: v};
				default: nxt = '{out_a: v,  out_b: p,  out_c: qv};
			endcase
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for rgb_hsv_converter: directed and random pixels in both modes,
// with an own-state predictor and an in-order checker. Depends on rhc_pkg, rhc_if, rgb_hsv_converter.
module testbench;
	import rhc_pkg::*;

	localparam int SECTOR    = int'(HUE_SPAN);
	localparam int LEVEL_MAX = int'(FULL);
	localparam int FRAC_MUL  = int'(REM_SCALE);
	localparam int HOLD_LEN  = 80;

	logic clk;
	logic arst_n;

	rhc_if #(.T(pixel_t))  pixel_ch ();
	rhc_if #(.T(result_t)) result_ch ();

	rgb_hsv_converter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_ch.sink),
		.result (result_ch.source)
	);

	result_t pending_pixels[$];
	int      errors;
	int      src_idle_pct;
	int      snk_idle_pct;
	int      hold_left;
	bit      hold_req;

	always #5 clk = ~clk;

	// Expected conversion of one pixel, integer arithmetic throughout
	function automatic result_t convert_pixel(pixel_t px);
		int a, b, c, hi, lo, sat, num, base;
		int region, frac, p, q, t, v, s;
		result_t r;
		a = int'(px.chan_a);
		b = int'(px.chan_b);
		c = int'(px.chan_c);
		r = '0;
		if (px.mode == MODE_TO_HSV) begin
			hi = (a > b) ? a : b;
			hi = (hi > c) ? hi : c;
			lo = (a < b) ? a : b;
			lo = (lo < c) ? lo : c;
			r.out_c = 8'(hi);
			if (hi != 0) begin
				sat = (LEVEL_MAX * (hi - lo)) / hi;
				r.out_b = 8'(sat);
				if (sat != 0) begin
					// red wins ties over green, green over blue
					if (hi == a) begin
						base = int'(BASE_RED);
						num  = b - c;
					end else if (hi == b) begin
						base = int'(BASE_GRN);
						num  = c - a;
					end else begin
						base = int'(BASE_BLU);
						num  = a - b;
					end
					r.out_a = 8'(base + (SECTOR * num) / (hi - lo));
				end
			end
		end else begin
			v = c;
			s = b;
			if (s == 0) begin
				r = {8'(v), 8'(v), 8'(v)};
			end else begin
				region = a / SECTOR;
				frac   = ((a - region * SECTOR) * FRAC_MUL) & 255;
				p = (v * (LEVEL_MAX - s)) >> 8;
				q = (v * (LEVEL_MAX - ((s * frac) >> 8))) >> 8;
				t = (v * (LEVEL_MAX - ((s * (LEVEL_MAX - frac)) >> 8))) >> 8;
				case (region)
					0: r = {8'(v), 8'(t), 8'(p)};
					1: r = {8'(q), 8'(v), 8'(p)};
					2: r = {8'(p), 8'(v), 8'(t)};
					3: r = {8'(p), 8'(q), 8'(v)};
					4: r = {8'(t), 8'(p), 8'(v)};
					default: r = {8'(v), 8'(p), 8'(q)};
				endcase
			end
		end
		return r;
	endfunction

	function automatic pixel_t make_pixel(mode_t m, int a, int b, int c);
		pixel_t px;
		px.mode   = m;
		px.chan_a = 8'(a);
		px.chan_b = 8'(b);
		px.chan_c = 8'(c);
		return px;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		px.mode   = mode_t'($urandom_range(1));
		px.chan_a = 8'($urandom);
		px.chan_b = 8'($urandom);
		px.chan_c = 8'($urandom);
		case ($urandom_range(7))
			0: begin
				// grey pixel: all three channels equal
				px.chan_b = px.chan_a;
				px.chan_c = px.chan_a;
			end
			1: px.chan_b = $urandom_range(1) ? 8'hFF : 8'h00;
			2: px.chan_a = px.chan_c;
			default: ;
		endcase
		return px;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic send_pixel(pixel_t px);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			pixel_ch.valid <= 1'b0;
		end
		@(negedge clk);
		pixel_ch.valid <= 1'b1;
		pixel_ch.data  <= px;
		do @(posedge clk); while (!pixel_ch.ready);
	endtask

	// Receiver: random stalls, or a long hold when asked for
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_LEN;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Record each accepted pixel, then match each accepted result against the oldest one
	always @(posedge clk) begin : match_results
		result_t want;
		if (arst_n) begin
			if (pixel_ch.valid && pixel_ch.ready)
				pending_pixels.push_back(convert_pixel(pixel_ch.data));
			if (result_ch.valid && result_ch.ready) begin
				if (pending_pixels.size() == 0) begin
					$error("result %h arrived with nothing pending", result_ch.data);
					errors++;
				end else begin
					want = pending_pixels.pop_front();
					check_field("out_a", want.out_a, result_ch.data.out_a);
					check_field("out_b", want.out_b, result_ch.data.out_b);
					check_field("out_c", want.out_c, result_ch.data.out_c);
				end
			end
		end
	end

	task automatic test_rgb_to_hsv();
		send_pixel(make_pixel(MODE_TO_HSV, 0, 0, 0));
		send_pixel(make_pixel(MODE_TO_HSV, 255, 255, 255));
		send_pixel(make_pixel(MODE_TO_HSV, 128, 128, 128));
		send_pixel(make_pixel(MODE_TO_HSV, 255, 0, 0));
		send_pixel(make_pixel(MODE_TO_HSV, 0, 255, 0));
		send_pixel(make_pixel(MODE_TO_HSV, 0, 0, 255));
		send_pixel(make_pixel(MODE_TO_HSV, 255, 255, 0));
		send_pixel(make_pixel(MODE_TO_HSV, 0, 255, 255));
		send_pixel(make_pixel(MODE_TO_HSV, 255, 0, 255));
		// red on top with blue above green: hue wraps below zero
		send_pixel(make_pixel(MODE_TO_HSV, 255, 0, 10));
		send_pixel(make_pixel(MODE_TO_HSV, 1, 0, 0));
		send_pixel(make_pixel(MODE_TO_HSV, 255, 254, 254));
	endtask

	task automatic test_hsv_to_rgb();
		send_pixel(make_pixel(MODE_TO_RGB, 99, 0, 200));
		send_pixel(make_pixel(MODE_TO_RGB, 0, 255, 255));
		send_pixel(make_pixel(MODE_TO_RGB, 42, 255, 255));
		send_pixel(make_pixel(MODE_TO_RGB, 43, 255, 255));
		send_pixel(make_pixel(MODE_TO_RGB, 85, 255, 255));
		send_pixel(make_pixel(MODE_TO_RGB, 128, 255, 255));
		send_pixel(make_pixel(MODE_TO_RGB, 171, 200, 180));
		send_pixel(make_pixel(MODE_TO_RGB, 214, 255, 255));
		send_pixel(make_pixel(MODE_TO_RGB, 215, 255, 255));
		send_pixel(make_pixel(MODE_TO_RGB, 255, 255, 255));
		send_pixel(make_pixel(MODE_TO_RGB, 60, 255, 0));
		send_pixel(make_pixel(MODE_TO_RGB, 255, 1, 255));
	endtask

	task automatic test_random(int count, int src_pct, int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		repeat (count) send_pixel(random_pixel());
	endtask

	// Hold the receiver off while pixels keep coming, so the pipeline fills and stalls
	task automatic test_backpressure();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		@(negedge clk);
		hold_req = 1'b1;
		repeat (30) send_pixel(random_pixel());
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		pixel_ch.valid  = 1'b0;
		pixel_ch.data   = '0;
		result_ch.ready = 1'b0;
		errors          = 0;
		src_idle_pct    = 0;
		snk_idle_pct    = 0;
		hold_left       = 0;
		hold_req        = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_rgb_to_hsv();
		test_hsv_to_rgb();
		test_random(140, 35, 67);
		test_random(140, 67, 35);
		test_random(100, 0, 0);
		test_backpressure();

		@(negedge clk);
		pixel_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
src/rhc_pkg.sv
src/rhc_if.sv
src/rhc_front.sv
src/rhc_div_stage.sv
src/rhc_back.sv
src/rgb_hsv_converter.sv
dv/testbench.sv
